// ===== design/msr_pkg.sv =====
package msr_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SP_W   = $clog2(DEPTH + 1);

    localparam logic [SP_W-1:0] SP_FULL = SP_W'(DEPTH);

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_POP_EMPTY = 2'd1,
        STAT_PUSH_FULL = 2'd2
    } status_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic signed [DATA_W-1:0] max_value;
        logic [SP_W-1:0]          depth_now;
        logic                     is_empty;
        logic                     is_full;
        logic [1:0]               status;
    } result_t;

    // One stored level: the value and the running maximum up to it
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] max;
    } entry_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

endpackage

// ===== design/msr_store.sv =====
module msr_store (
    input  logic                clk,
    input  msr_pkg::store_req_t req,
    output msr_pkg::entry_t     rd_data
);
    import msr_pkg::*;

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/stack_with_running_max.sv =====
// Channel   Ports                     Handshake
// ------    ------------------------  ------------------------------------
// request   start, busy, request      item taken when start && !busy
// result    done, result              one result per item, done strobe
//
// A push's result appears on the cycle after acceptance.
// A pop that leaves entries behind waits for the store: the entry below the top
// comes from the store's registered read port, and busy is high while it lands.
// Other pops and all rejected operations give their result with no wait.
// Reset (rst_n low) empties the stack at once; the store is not cleared.
// The receiver cannot stall; every item gives exactly one result.
module stack_with_running_max (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  msr_pkg::request_t request,
    output logic              done,
    output msr_pkg::result_t  result
);
    import msr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [SP_W-1:0]          sp_reg, sp_next;
    logic signed [DATA_W-1:0] top_val_reg, top_val_next;
    logic signed [DATA_W-1:0] top_max_reg, top_max_next;
    logic                     done_reg, done_next;
    result_t                  result_reg, result_next;

    store_req_t               store_req;
    entry_t                   store_rd;
    logic [SP_W-1:0]          sp_minus1;
    logic [SP_W-1:0]          sp_minus2;

    msr_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (store_rd)
    );

    function automatic result_t make_result(
        input logic [SP_W-1:0]          sp,
        input logic signed [DATA_W-1:0] top,
        input logic signed [DATA_W-1:0] mx,
        input status_t                  st
    );
        result_t r;
        r.top_value = (sp == '0) ? '0 : top;
        r.max_value = (sp == '0) ? '0 : mx;
        r.depth_now = sp;
        r.is_empty  = (sp == '0);
        r.is_full   = (sp == SP_FULL);
        r.status    = st;
        return r;
    endfunction

    assign sp_minus1 = sp_reg - SP_W'(1);
    assign sp_minus2 = sp_reg - SP_W'(2);

    always_comb
    begin
        state_next        = state_reg;
        sp_next           = sp_reg;
        top_val_next      = top_val_reg;
        top_max_next      = top_max_reg;
        done_next         = 1'b0;
        result_next       = result_reg;
        store_req.wr_en   = 1'b0;
        store_req.wr_addr = sp_minus1[ADDR_W-1:0];
        store_req.wr_data = '{value: top_val_reg, max: top_max_reg};
        store_req.rd_en   = 1'b0;
        store_req.rd_addr = sp_minus2[ADDR_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    if (request.cmd == CMD_PUSH)
                    begin
                        if (sp_reg == SP_FULL)
                        begin
                            result_next = make_result(sp_reg, top_val_reg, top_max_reg,
                                                      STAT_PUSH_FULL);
                        end
                        else
                        begin
                            // spill the current top into the store
                            store_req.wr_en = (sp_reg != '0);
                            top_val_next    = request.value;
                            top_max_next    = (sp_reg == '0 || request.value > top_max_reg)
                                              ? request.value : top_max_reg;
                            sp_next         = sp_reg + SP_W'(1);
                            result_next     = make_result(sp_next, top_val_next,
                                                          top_max_next, STAT_OK);
                        end
                    end
                    else
                    begin
                        if (sp_reg == '0)
                        begin
                            result_next = make_result(sp_reg, top_val_reg, top_max_reg,
                                                      STAT_POP_EMPTY);
                        end
                        else if (sp_reg == SP_W'(1))
                        begin
                            sp_next     = '0;
                            result_next = make_result('0, top_val_reg, top_max_reg, STAT_OK);
                        end
                        else
                        begin
                            // fetch the entry below; result follows when it lands
                            done_next       = 1'b0;
                            store_req.rd_en = 1'b1;
                            sp_next         = sp_minus1;
                            state_next      = S_POP_WAIT;
                        end
                    end
                end
            end
            S_POP_WAIT:
            begin
                top_val_next = store_rd.value;
                top_max_next = store_rd.max;
                done_next    = 1'b1;
                result_next  = make_result(sp_reg, store_rd.value, store_rd.max, STAT_OK);
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_val_reg <= top_val_next;
        top_max_reg <= top_max_next;
        result_reg  <= result_next;
    end

    assign busy   = (state_reg == S_POP_WAIT);
    assign done   = done_reg;
    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_FULL)
        else $error("stack pointer beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("pop fetch did not complete in one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.cmd == CMD_POP && sp_reg > SP_W'(1)) |=> busy && !done)
        else $error("deep pop did not wait for the store");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.depth_now == sp_reg) && (result.is_empty == (sp_reg == '0)))
        else $error("reported depth disagrees with stack pointer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.is_empty) |-> result.max_value >= result.top_value)
        else $error("running maximum below top value");

endmodule
